// ===== hw/rtl/ob_pkg.sv =====
// shared types and constants for the rgba8 overlay blend block
package ob_pkg;

	// pipeline depth from input register to result register
	localparam int NUM_STAGES = 7;

	// widths of the two divide-by-255 steps
	localparam int NUM_W = 24;
	localparam int Q1_W  = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd1;

	localparam logic [7:0] OPACITY_RESET = 8'd128;

	// blend mode codes, the unused code falls back to alpha over
	localparam logic [1:0] MODE_ALPHA    = 2'd0;
	localparam logic [1:0] MODE_ADDITIVE = 2'd1;
	localparam logic [1:0] MODE_MULTIPLY = 2'd2;

	// per-stage load enables, index is the stage number
	typedef logic [NUM_STAGES:1] stage_en_t;

endpackage

// ===== hw/rtl/ob_in_if.sv =====
// input pixel channel: destination rgba8 and overlay rgb8
interface ob_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] dest_red;
	logic [7:0] dest_green;
	logic [7:0] dest_blue;
	logic [7:0] dest_alpha;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;

	modport source (
		output valid, dest_red, dest_green, dest_blue, dest_alpha,
		       src_red, src_green, src_blue,
		input  ready
	);
	modport sink (
		input  valid, dest_red, dest_green, dest_blue, dest_alpha,
		       src_red, src_green, src_blue,
		output ready
	);
endinterface

// ===== hw/rtl/ob_out_if.sv =====
// output pixel channel: blended rgba8
interface ob_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

// ===== hw/rtl/ob_div255.sv =====
// two-stage floor division by 255: reciprocal estimate, then one correction
module ob_div255 #(
	parameter int W = ob_pkg::NUM_W
) (
	input  logic         clk,
	input  logic         en1,
	input  logic         en2,
	input  logic [W-1:0] num,
	output logic [W-8:0] quo
);

	logic [W+8:0] prod;
	logic [W-8:0] q0_s1;
	logic [W-1:0] num_s1;
	logic [W:0]   q255;
	logic [W:0]   rem;

	// estimate num*257/65536, low by at most one
	assign prod = {9'd0, num} + {1'b0, num, 8'd0};

	always_ff @(posedge clk) begin
		if (en1) begin
			q0_s1  <= prod[W+8:16];
			num_s1 <= num;
		end
	end

	// remainder against the estimate, bump the quotient when it reaches 255
	assign q255 = {q0_s1, 8'd0} - {8'd0, q0_s1};
	assign rem  = {1'b0, num_s1} - q255;

	always_ff @(posedge clk) begin
		if (en2) begin
			quo <= (rem >= (W+1)'(255)) ? q0_s1 + (W-7)'(1) : q0_s1;
		end
	end

endmodule

// ===== hw/rtl/ob_lane.sv =====
// one color channel of the blend pipeline, stages one to seven
module ob_lane import ob_pkg::*; (
	input  logic       clk,
	input  stage_en_t  en,
	input  logic [7:0] d,
	input  logic [7:0] s,
	input  logic [7:0] a,
	input  logic [1:0] mode,
	output logic [7:0] res
);

	logic [7:0]  d_s1, s_s1, a_s1;
	logic [1:0]  mode_s1;
	logic [15:0] sa_s2, dna_s2;
	logic [7:0]  d_s2, a_s2;
	logic [1:0]  mode_s2;
	logic [16:0] fac;
	logic [23:0] dfac;
	logic [23:0] num_d;
	logic [23:0] num_s3;
	logic [7:0]  d_s3, d_s4, d_s5, d_s6, d_s7;
	logic [1:0]  mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic [NUM_W-8:0] q1;
	logic [Q1_W-8:0]  q2;
	logic [7:0]  q1lo_s6, q1lo_s7;
	logic [8:0]  sum;

	// input register
	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1    <= d;
			s_s1    <= s;
			a_s1    <= a;
			mode_s1 <= mode;
		end
	end

	// source and destination products
	always_ff @(posedge clk) begin
		if (en[2]) begin
			sa_s2   <= s_s1 * a_s1;
			dna_s2  <= d_s1 * (8'd255 - a_s1);
			d_s2    <= d_s1;
			a_s2    <= a_s1;
			mode_s2 <= mode_s1;
		end
	end

	// multiply factor 65025 - 255a + sa and rounded numerator per mode
	assign fac  = 17'd65025 + {1'b0, sa_s2} - ({1'b0, a_s2, 8'd0} - {9'd0, a_s2});
	assign dfac = d_s2 * fac[15:0];

	always_comb begin
		case (mode_s2)
			MODE_ADDITIVE: num_d = {8'd0, sa_s2} + 24'd127;
			MODE_MULTIPLY: num_d = dfac + 24'd32512;
			default:       num_d = {8'd0, sa_s2} + {8'd0, dna_s2} + 24'd127;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s3  <= num_d;
			d_s3    <= d_s2;
			mode_s3 <= mode_s2;
		end
	end

	// first divide by 255, stages four and five
	ob_div255 #(.W(NUM_W)) u_div1 (
		.clk (clk),
		.en1 (en[4]),
		.en2 (en[5]),
		.num (num_s3),
		.quo (q1)
	);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			d_s4    <= d_s3;
			mode_s4 <= mode_s3;
		end
		if (en[5]) begin
			d_s5    <= d_s4;
			mode_s5 <= mode_s4;
		end
	end

	// second divide by 255 for multiply mode, stages six and seven
	ob_div255 #(.W(Q1_W)) u_div2 (
		.clk (clk),
		.en1 (en[6]),
		.en2 (en[7]),
		.num (q1[Q1_W-1:0]),
		.quo (q2)
	);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			d_s6    <= d_s5;
			mode_s6 <= mode_s5;
			q1lo_s6 <= q1[7:0];
		end
		if (en[7]) begin
			d_s7    <= d_s6;
			mode_s7 <= mode_s6;
			q1lo_s7 <= q1lo_s6;
		end
	end

	// final pick, additive adds the destination and saturates
	assign sum = {1'b0, d_s7} + {1'b0, q1lo_s7};

	always_comb begin
		case (mode_s7)
			MODE_ADDITIVE: res = sum[8] ? 8'hFF : sum[7:0];
			MODE_MULTIPLY: res = q2[7:0];
			default:       res = q1lo_s7;
		endcase
	end

endmodule

// ===== hw/rtl/rgba8_overlay_blend.sv =====
// Top level of the rgba8 overlay blend block.
// Throughput: one pixel per cycle while the output is ready; each stage loads
// whenever it is empty or the next moves, so bubbles close up under backpressure.
// Most of the depth comes from the two chained divide-by-255 units (two stages each).
// Reset clears all valid bits, opacity to 128 and blend mode to alpha over.
module rgba8_overlay_blend import ob_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ob_in_if.sink                 pix_in,
	ob_out_if.source              pix_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0] opacity_q;
	logic [1:0] mode_q;
	stage_en_t  v_q;
	stage_en_t  en;

	// configuration registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= OPACITY_RESET;
			mode_q    <= MODE_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPACITY:    opacity_q <= cfg_data[7:0];
				REG_BLEND_MODE: mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// stage load enables, from the output back to the input
	always_comb begin
		en[NUM_STAGES] = !v_q[NUM_STAGES] || pix_out.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= pix_in.valid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign pix_in.ready  = en[1];
	assign pix_out.valid = v_q[NUM_STAGES];

	// color lanes
	ob_lane u_red (
		.clk (clk), .en (en), .d (pix_in.dest_red), .s (pix_in.src_red),
		.a (opacity_q), .mode (mode_q), .res (pix_out.out_red)
	);
	ob_lane u_green (
		.clk (clk), .en (en), .d (pix_in.dest_green), .s (pix_in.src_green),
		.a (opacity_q), .mode (mode_q), .res (pix_out.out_green)
	);
	ob_lane u_blue (
		.clk (clk), .en (en), .d (pix_in.dest_blue), .s (pix_in.src_blue),
		.a (opacity_q), .mode (mode_q), .res (pix_out.out_blue)
	);

	// alpha is a lane with a full-scale source: over, da+a, or da unchanged
	ob_lane u_alpha (
		.clk (clk), .en (en), .d (pix_in.dest_alpha), .s (8'hFF),
		.a (opacity_q), .mode (mode_q), .res (pix_out.out_alpha)
	);

`ifndef NO_ASSERTIONS
	// an empty output stage lets the whole pipeline advance
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[NUM_STAGES] |-> pix_in.ready)
		else $error("input stalled with output stage empty");

	// an accepted beat occupies stage one on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> v_q[1])
		else $error("accepted beat missing from stage one");

	// a stalled output stage keeps its beat
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NUM_STAGES] && !pix_out.ready |=> v_q[NUM_STAGES] && !en[NUM_STAGES-1]
		|| v_q[NUM_STAGES])
		else $error("stalled output beat dropped");

	// an opacity write takes effect on the next cycle
	a_opacity_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_OPACITY |=> opacity_q == $past(cfg_data[7:0]))
		else $error("opacity write lost");
`endif

endmodule

// ===== dv/rgba8_overlay_blend_tb.sv =====
// self-checking testbench for the rgba8 overlay blend block
module rgba8_overlay_blend_tb import ob_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// full-scale channel value and its square, the two divisors of the blend
	localparam int unsigned FULL    = 255;
	localparam int unsigned FULL_SQ = FULL * FULL;

	// mode code with no meaning of its own, behaves as alpha over
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int NUM_PHASES     = 12;
	localparam int PHASE_PIXELS   = 120;
	localparam int LONG_HOLD      = 80;
	localparam longint RUN_LIMIT  = 5_000_000;

	typedef struct packed {
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
		logic [7:0] dest_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ob_in_if  pix_in ();
	ob_out_if pix_out ();

	rgba8_overlay_blend dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the two registers
	logic [7:0] opacity_shadow = OPACITY_RESET;
	logic [1:0] mode_shadow    = MODE_ALPHA;

	pixel_in_t  pixel_queue[$];
	pixel_out_t blended_queue[$];

	int err_cnt     = 0;
	bit in_beat     = 1'b0;
	int in_gap      = 0;
	int out_stall   = 0;
	int hold_left   = 0;
	int hold_asked  = 0;
	int hold_served = 0;
	bit steady      = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// round(num / den), halves up
	function automatic int unsigned div_round(int unsigned num, int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic logic [7:0] mix_channel(logic [7:0] d, logic [7:0] s,
			logic [7:0] a, logic [1:0] m);
		int unsigned du;
		int unsigned su;
		int unsigned au;
		int unsigned v;
		du = d;
		su = s;
		au = a;
		case (m)
			MODE_ADDITIVE: begin
				v = div_round(FULL * du + su * au, FULL);
				if (v > FULL)
					v = FULL;
			end
			MODE_MULTIPLY: v = div_round(du * (FULL_SQ - FULL * au + su * au), FULL_SQ);
			default: v = div_round(su * au + du * (FULL - au), FULL);
		endcase
		return v[7:0];
	endfunction

	function automatic pixel_out_t predict_pixel(pixel_in_t p, logic [7:0] a, logic [1:0] m);
		pixel_out_t r;
		int unsigned da;
		int unsigned au;
		int unsigned v;
		da = p.dest_alpha;
		au = a;
		r.red   = mix_channel(p.dest_red, p.src_red, a, m);
		r.green = mix_channel(p.dest_green, p.src_green, a, m);
		r.blue  = mix_channel(p.dest_blue, p.src_blue, a, m);
		case (m)
			MODE_ADDITIVE: v = (da + au > FULL) ? FULL : da + au;
			MODE_MULTIPLY: v = da;
			default: v = div_round(FULL * au + da * (FULL - au), FULL);
		endcase
		r.alpha = v[7:0];
		return r;
	endfunction

	// idle length: mostly none, sometimes short, rarely long
	function automatic int draw_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// channel value biased toward the extremes
	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	// input driver: next beat or gap once the current beat is taken
	always @(negedge clk) begin
		pixel_in_t px;
		if (!pix_in.valid || in_beat) begin
			if (in_gap > 0) begin
				in_gap--;
				pix_in.valid <= 1'b0;
			end else if (pixel_queue.size() != 0) begin
				px = pixel_queue.pop_front();
				pix_in.dest_red   <= px.dest_red;
				pix_in.dest_green <= px.dest_green;
				pix_in.dest_blue  <= px.dest_blue;
				pix_in.dest_alpha <= px.dest_alpha;
				pix_in.src_red    <= px.src_red;
				pix_in.src_green  <= px.src_green;
				pix_in.src_blue   <= px.src_blue;
				pix_in.valid      <= 1'b1;
				in_gap = draw_idle();
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	// output ready: long hold-off on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_out.ready <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall--;
			pix_out.ready <= 1'b0;
		end else begin
			out_stall = draw_idle();
			pix_out.ready <= (out_stall == 0);
		end
	end

	// result check, then prediction for the input beat of this edge
	always @(posedge clk) begin
		pixel_in_t  px;
		pixel_out_t want;
		if (pix_out.valid === 1'b1 && pix_out.ready) begin
			if (blended_queue.size() == 0) begin
				$error("result beat with no pixel expected");
				err_cnt++;
			end else begin
				want = blended_queue.pop_front();
				check_field("out_red", want.red, pix_out.out_red);
				check_field("out_green", want.green, pix_out.out_green);
				check_field("out_blue", want.blue, pix_out.out_blue);
				check_field("out_alpha", want.alpha, pix_out.out_alpha);
			end
		end
		in_beat = pix_in.valid && pix_in.ready;
		if (in_beat) begin
			px = '{pix_in.dest_red, pix_in.dest_green, pix_in.dest_blue, pix_in.dest_alpha,
				pix_in.src_red, pix_in.src_green, pix_in.src_blue};
			blended_queue.push_back(predict_pixel(px, opacity_shadow, mode_shadow));
		end
	end

	task automatic push_pixel(logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da,
			logic [7:0] sr, logic [7:0] sg, logic [7:0] sb);
		pixel_queue.push_back('{dr, dg, db, da, sr, sg, sb});
	endtask

	// wait until every pixel is sent and every result has come back
	task automatic settle();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || pix_in.valid || blended_queue.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_OPACITY:    opacity_shadow = data[7:0];
			REG_BLEND_MODE: mode_shadow = data[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// new setting once idle; upper mode bits and unused indexes are junk
	task automatic reconfigure(logic [7:0] op, logic [1:0] mode);
		logic [CFG_DATA_W-1:0] junk;
		settle();
		write_reg(REG_OPACITY, op);
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_BLEND_MODE, {junk[CFG_DATA_W-1:2], mode});
		if ($urandom_range(0, 1) == 1) begin
			for (int i = REG_BLEND_MODE + 1; i < 2 ** CFG_IDX_W; i++)
				write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		end
	endtask

	initial begin
		logic [7:0] op;
		logic [1:0] mode;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		pix_in.valid      = 1'b0;
		pix_in.dest_red   = '0;
		pix_in.dest_green = '0;
		pix_in.dest_blue  = '0;
		pix_in.dest_alpha = '0;
		pix_in.src_red    = '0;
		pix_in.src_green  = '0;
		pix_in.src_blue   = '0;
		pix_out.ready     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset setting is alpha over at about half opacity
		push_pixel(0, 0, 0, 0, 0, 0, 0);
		push_pixel(255, 255, 255, 255, 255, 255, 255);
		push_pixel(255, 255, 255, 255, 0, 0, 0);
		push_pixel(0, 0, 0, 0, 255, 255, 255);
		push_pixel(170, 85, 1, 128, 254, 2, 127);

		// additive at full opacity, saturating colour and alpha
		reconfigure(8'd255, MODE_ADDITIVE);
		push_pixel(255, 255, 255, 255, 255, 255, 255);
		push_pixel(200, 100, 0, 200, 255, 128, 1);
		push_pixel(0, 0, 0, 0, 0, 0, 0);

		// multiply at both opacity extremes
		reconfigure(8'd255, MODE_MULTIPLY);
		push_pixel(255, 255, 255, 255, 0, 128, 255);
		push_pixel(1, 128, 254, 77, 255, 0, 1);
		reconfigure(8'd0, MODE_MULTIPLY);
		push_pixel(255, 255, 255, 255, 0, 0, 0);

		// unused mode code falls back to alpha over
		reconfigure(8'd0, MODE_SPARE);
		push_pixel(12, 34, 56, 78, 255, 255, 255);
		push_pixel(255, 255, 255, 0, 0, 0, 0);

		// opaque overlay in alpha over
		reconfigure(8'd255, MODE_ALPHA);
		push_pixel(10, 20, 30, 40, 50, 60, 70);

		// random phases: every mode at zero, full and random opacity
		for (int p = 0; p < NUM_PHASES; p++) begin
			mode = 2'(p % 4);
			case (p % 3)
				0: op = 8'd0;
				1: op = 8'd255;
				default: op = 8'($urandom_range(1, 254));
			endcase
			reconfigure(op, mode);
			steady = (p % 5 == 4);
			for (int k = 0; k < PHASE_PIXELS; k++)
				push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
					rand_byte(), rand_byte(), rand_byte());
			// long output hold-off while the input keeps offering pixels
			if (p == 2 || p == 7)
				hold_asked++;
		end

		settle();
		repeat (NUM_STAGES * 4) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#RUN_LIMIT;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ob_pkg.sv
hw/rtl/ob_in_if.sv
hw/rtl/ob_out_if.sv
hw/rtl/ob_div255.sv
hw/rtl/ob_lane.sv
hw/rtl/rgba8_overlay_blend.sv
dv/rgba8_overlay_blend_tb.sv
